// File: src/mcid_pkg.sv
// Shared types for the multi-code input debouncer.
// Holds the filter state encoding and the event kind codes; no dependencies.
`default_nettype none

package mcid_pkg;

  // Filter state encoding
  typedef enum logic [3:0] {
    ST_INIT  = 4'd0,
    ST_P1    = 4'd1,
    ST_P2    = 4'd2,
    ST_P3    = 4'd3,
    ST_R1    = 4'd4,
    ST_R2    = 4'd5,
    ST_R3    = 4'd6,
    ST_PEDGE = 4'd7,
    ST_PRESS = 4'd8,
    ST_REDGE = 4'd9,
    ST_REL   = 4'd10
  } filter_state_t;

  // Event kinds reported on the result channel
  typedef enum logic [1:0] {
    EV_PRESS_EDGE   = 2'd0,
    EV_PRESS        = 2'd1,
    EV_RELEASE_EDGE = 2'd2,
    EV_RELEASED     = 2'd3
  } event_kind_t;

  localparam int unsigned CODE_W = 8;

endpackage

`default_nettype wire

// File: src/multi_code_input_debouncer_unit.sv
// Multi-code input debouncer: one scan sample per transaction.
// The block reports press and release events after three matching filter steps.
// Depends on mcid_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_sample_code) carries one scan tick
//   per transaction. Result channel (out_valid / out_stall / out_event_*)
//   carries zero or one event per scan tick, in tick order.
//   cfg_wr_en / cfg_wr_data write idle_code; write it only while no sample is
//   in flight.
// Pipeline and throughput:
//   A sample is captured in an input register, then the filter update runs and
//   loads the result register, from which the event is offered. One sample per
//   cycle is sustained while out_stall does not hold a waiting event; the single
//   state update per cycle (filter state and stored code) sets that figure.
// Reset:
//   Synchronous active-low reset clears the filter state to initial, the stored
//   code and idle_code to zero, and empties both registers.
// Stall:
//   While out_stall holds a waiting event, the filter stage does not advance;
//   a captured sample waits in the input register and in_stall is raised.
`default_nettype none

module multi_code_input_debouncer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [mcid_pkg::CODE_W-1:0]   cfg_wr_data,
  // sample channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mcid_pkg::CODE_W-1:0]   in_sample_code,
  // event channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mcid_pkg::event_kind_t              out_event_kind,
  output logic [mcid_pkg::CODE_W-1:0]        out_event_code
);
  import mcid_pkg::*;

  logic [CODE_W-1:0] idle_code_r;
  logic              in_vld_r;
  logic [CODE_W-1:0] in_code_r;
  filter_state_t     state_r, state_nxt;
  logic [CODE_W-1:0] stored_code_r;
  logic              out_vld_r;
  event_kind_t       out_kind_r;
  logic [CODE_W-1:0] out_code_r;

  logic        out_free;
  logic        proc_go;
  logic        is_idle;
  logic        code_chg;
  logic        emit;
  event_kind_t kind;

  // Result register can take a new event this cycle
  assign out_free = !out_vld_r || !out_stall;
  assign proc_go  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  assign is_idle  = (in_code_r == idle_code_r);
  assign code_chg = (in_code_r != stored_code_r);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_code_r <= '0;
    end else if (cfg_wr_en) begin
      idle_code_r <= cfg_wr_data;
    end
  end

  // Input register: load when empty or when its sample moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_code_r <= in_sample_code;
    end
  end

  // Next filter state
  always_comb begin
    state_nxt = state_r;
    if (code_chg) begin
      state_nxt = is_idle ? ST_R1 : ST_P1;
    end else begin
      case (state_r)
        ST_P1:    state_nxt = is_idle ? ST_R1 : ST_P2;
        ST_P2:    state_nxt = is_idle ? ST_R1 : ST_P3;
        ST_P3:    state_nxt = is_idle ? ST_R1 : ST_PEDGE;
        ST_R1:    state_nxt = is_idle ? ST_R2 : ST_P1;
        ST_R2:    state_nxt = is_idle ? ST_R3 : ST_P1;
        ST_R3:    state_nxt = is_idle ? ST_REDGE : ST_P1;
        ST_PEDGE,
        ST_PRESS: state_nxt = is_idle ? ST_R1 : ST_PRESS;
        ST_REDGE,
        ST_REL:   state_nxt = is_idle ? ST_REL : ST_P1;
        default:  state_nxt = is_idle ? ST_R1 : ST_P1;
      endcase
    end
  end

  // Event decode for an unchanged code
  always_comb begin
    emit = 1'b0;
    kind = EV_PRESS_EDGE;
    if (!code_chg) begin
      case (state_r)
        ST_P3: begin
          emit = !is_idle;
          kind = EV_PRESS_EDGE;
        end
        ST_R3: begin
          emit = is_idle;
          kind = EV_RELEASE_EDGE;
        end
        ST_PEDGE, ST_PRESS: begin
          emit = !is_idle;
          kind = EV_PRESS;
        end
        ST_REDGE, ST_REL: begin
          emit = is_idle;
          kind = EV_RELEASED;
        end
        default: begin
          emit = 1'b0;
          kind = EV_PRESS_EDGE;
        end
      endcase
    end
  end

  // Filter state and stored code advance once per processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      stored_code_r <= '0;
    end else if (proc_go) begin
      state_r       <= state_nxt;
      stored_code_r <= in_code_r;
    end
  end

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= proc_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      out_kind_r <= kind;
      out_code_r <= stored_code_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_kind = out_kind_r;
  assign out_event_code = out_code_r;

  // An emitted event carries the stored code, which an event never changes
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && emit) |=> (out_vld_r && out_code_r == stored_code_r))
    else $error("event not loaded with stored code");

  // A sample blocked by a waiting event stays put in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_free) |=> (in_vld_r && $stable(in_code_r)))
    else $error("blocked sample lost");

  // A changed code always restarts a filter and produces no event
  a_chg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && code_chg) |=> ((state_r == ST_P1 || state_r == ST_R1)
                               && stored_code_r == $past(in_code_r)))
    else $error("changed code did not restart filter");

  a_chg_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && code_chg && out_free) |=> !out_vld_r)
    else $error("event emitted on changed code");

endmodule

`default_nettype wire
